### rtl/dnle_pkg.sv
// shared constants and types for the dns name label encoder
package dnle_pkg;

  localparam int unsigned MAX_LABEL = 63;
  localparam int unsigned CNT_W     = $clog2(MAX_LABEL + 1);
  localparam int unsigned ADDR_W    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam int unsigned CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

  // request bundle into the label store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/dnle_chan_if.sv
// valid/ready channel interfaces for host name characters and encoded bytes
interface dnle_char_if;
  logic                        valid;
  logic                        ready;
  logic [dnle_pkg::CHAR_W-1:0] char_value;
  logic                        end_of_name;

  modport source (output valid, output char_value, output end_of_name, input ready);
  modport sink   (input valid, input char_value, input end_of_name, output ready);
endinterface

interface dnle_byte_if;
  logic                        valid;
  logic                        ready;
  logic [dnle_pkg::CHAR_W-1:0] byte_value;
  logic                        last;
  logic                        root_after;
  logic                        error;

  modport source (output valid, output byte_value, output last, output root_after,
                  output error, input ready);
  modport sink   (input valid, input byte_value, input last, input root_after,
                  input error, output ready);
endinterface

### rtl/dnle_label_ram.sv
// label character store, one write port and one registered read port
module dnle_label_ram (
  input  logic                            clk_i,
  input  dnle_pkg::ram_req_t              req_i,
  output logic [dnle_pkg::CHAR_W-1:0]     rdata_o
);

  logic [dnle_pkg::CHAR_W-1:0] mem [0:dnle_pkg::MAX_LABEL-1];
  logic [dnle_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dns_name_label_encoder.sv
// top level: dotted host name to dns wire-format label encoder
// Characters of a host name arrive one per item; each non-dot character is
// written into a 63-entry label store and produces no output.
// A dot, or an item with end_of_name set, flushes the buffered label: the
// length byte comes first, then the stored characters in order, one byte per
// cycle while the sink takes them. A flush runs through the accepting item,
// the length byte and then each stored character, with the input closed
// from the flush until the last byte of the run is in the output register.
// The label store is read one entry ahead of the output register.
// The last byte of a run has last set, and root_after as well when the run
// came from end_of_name (the zero root byte is left to the consumer).
// Characters beyond 63 are dropped; an overlong or empty label sets error on
// every byte of its run, and an empty label is the single byte zero. Input
// stays open while a finished byte waits in the output register.
module dns_name_label_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  dnle_char_if.sink         in_i,
  dnle_byte_if.source       out_o
);

  typedef enum logic [1:0] {
    S_IN,    // taking characters
    S_LEN,   // emitting the length byte
    S_DATA   // streaming stored characters
  } state_e;

  state_e                        state_q, state_d;
  logic [dnle_pkg::CNT_W-1:0]    count_q, count_d;     // characters buffered
  logic                          ovf_q, ovf_d;         // a character was dropped
  logic [dnle_pkg::CNT_W-1:0]    len_q, len_d;         // label length of the run
  logic                          err_q, err_d;
  logic                          eon_q, eon_d;
  logic [dnle_pkg::ADDR_W-1:0]   idx_q, idx_d;         // character being emitted

  // output register
  logic                          oval_q, oval_d;
  logic [dnle_pkg::CHAR_W-1:0]   obyte_q, obyte_d;
  logic                          olast_q, olast_d;
  logic                          oroot_q, oroot_d;
  logic                          oerr_q, oerr_d;

  dnle_pkg::ram_req_t            ram_req;
  logic [dnle_pkg::CHAR_W-1:0]   ram_rdata;

  logic in_acc;
  logic is_flush;
  logic out_free;
  logic data_last;

  dnle_label_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IN);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_flush   = in_i.end_of_name || (in_i.char_value == dnle_pkg::DOT_CHAR);
  // output register can take a new byte this cycle
  assign out_free   = !oval_q || out_o.ready;
  assign data_last  = (dnle_pkg::CNT_W'(idx_q) == (len_q - dnle_pkg::CNT_W'(1)));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    len_d   = len_q;
    err_d   = err_q;
    eon_d   = eon_q;
    idx_d   = idx_q;
    oval_d  = oval_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    oroot_d = oroot_q;
    oerr_d  = oerr_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = count_q[dnle_pkg::ADDR_W-1:0];
    ram_req.wdata = in_i.char_value;
    ram_req.re    = 1'b0;
    ram_req.raddr = '0;

    if (oval_q && out_o.ready) begin
      oval_d = 1'b0;
    end

    case (state_q)
      S_IN: begin
        if (in_acc) begin
          if (!is_flush) begin
            if (count_q < dnle_pkg::CNT_W'(dnle_pkg::MAX_LABEL)) begin
              ram_req.we = 1'b1;
              count_d    = count_q + dnle_pkg::CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            // snapshot the label, clear the buffer bookkeeping
            len_d   = count_q;
            err_d   = (count_q == '0) || ovf_q;
            eon_d   = in_i.end_of_name;
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = dnle_pkg::CHAR_W'(len_q);
          olast_d = (len_q == '0);
          oroot_d = (len_q == '0) && eon_q;
          oerr_d  = err_q;
          if (len_q == '0) begin
            state_d = S_IN;
          end else begin
            // fetch the first character ahead of its slot
            ram_req.re    = 1'b1;
            ram_req.raddr = '0;
            idx_d         = '0;
            state_d       = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          oval_d  = 1'b1;
          obyte_d = ram_rdata;
          olast_d = data_last;
          oroot_d = data_last && eon_q;
          oerr_d  = err_q;
          if (data_last) begin
            state_d = S_IN;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_q + dnle_pkg::ADDR_W'(1);
            idx_d         = idx_q + dnle_pkg::ADDR_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      count_q <= '0;
      ovf_q   <= 1'b0;
      len_q   <= '0;
      err_q   <= 1'b0;
      eon_q   <= 1'b0;
      idx_q   <= '0;
      oval_q  <= 1'b0;
      obyte_q <= '0;
      olast_q <= 1'b0;
      oroot_q <= 1'b0;
      oerr_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      err_q   <= err_d;
      eon_q   <= eon_d;
      idx_q   <= idx_d;
      oval_q  <= oval_d;
      obyte_q <= obyte_d;
      olast_q <= olast_d;
      oroot_q <= oroot_d;
      oerr_q  <= oerr_d;
    end
  end

  assign out_o.valid      = oval_q;
  assign out_o.byte_value = obyte_q;
  assign out_o.last       = olast_q;
  assign out_o.root_after = oroot_q;
  assign out_o.error      = oerr_q;

endmodule

### tb/tb_dns_name_label_encoder.sv
// self-checking testbench for the dns name label encoder
module tb_dns_name_label_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // input items to queue before the random part stops, directed part included
  localparam int unsigned NUM_ITEMS  = 460;
  // window of cycles in which neither side idles at random
  localparam int unsigned QUIET_FROM = 600;
  localparam int unsigned QUIET_TO   = 1400;
  // cycles allowed after the last expected byte before the verdict
  localparam int unsigned TAIL_CYCLES = 100;

  // one host name character as it sits in the pending queue
  typedef struct packed {
    logic [dnle_pkg::CHAR_W-1:0] char_value;
    logic                        end_of_name;
    logic                        drain_first;  // hold this item until all bytes are out
  } name_char_t;

  // one encoded wire byte with its flags
  typedef struct packed {
    logic [dnle_pkg::CHAR_W-1:0] byte_value;
    logic                        last;
    logic                        root_after;
    logic                        error;
  } wire_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dnle_char_if name_chars ();
  dnle_byte_if wire_bytes ();

  dns_name_label_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (name_chars),
    .out_o  (wire_bytes)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  name_char_t  pending_chars[$];
  wire_byte_t  expected_bytes[$];
  name_char_t  in_flight;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned queued_count;
  bit          drain_next;

  // shadow copy of the label buffer kept by the encoder
  logic [dnle_pkg::CHAR_W-1:0] held_chars [dnle_pkg::MAX_LABEL];
  logic [dnle_pkg::CNT_W-1:0]  held_len = '0;
  bit                          held_dropped = 1'b0;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // random idling at about 11 percent, off inside the quiet window
  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  // works out the wire bytes one accepted character causes
  // plain characters only fill the label buffer, a dot or an end flushes it
  function automatic void predict_wire_bytes(name_char_t it);
    wire_byte_t wb;
    int unsigned n;
    logic err;
    if (!it.end_of_name && it.char_value != dnle_pkg::DOT_CHAR) begin
      // characters past the label limit are dropped and remembered
      if (held_len < dnle_pkg::MAX_LABEL) begin
        held_chars[held_len] = it.char_value;
        held_len = held_len + 1'b1;
      end else begin
        held_dropped = 1'b1;
      end
      return;
    end
    n   = held_len;
    // empty or overlong label flags every byte of its run
    err = (n == 0) || held_dropped;
    // length byte first; for an empty label it is the whole run
    wb.byte_value = n[dnle_pkg::CHAR_W-1:0];
    wb.last       = (n == 0);
    wb.root_after = (n == 0) ? it.end_of_name : 1'b0;
    wb.error      = err;
    expected_bytes.push_back(wb);
    for (int unsigned i = 0; i < n; i++) begin
      wb.byte_value = held_chars[i];
      wb.last       = (i + 1 == n);
      wb.root_after = (i + 1 == n) ? it.end_of_name : 1'b0;
      wb.error      = err;
      expected_bytes.push_back(wb);
    end
    held_len     = '0;
    held_dropped = 1'b0;
  endfunction

  // driver: offers the next pending item whenever the slot is free, unless it idles or a drain item waits
  // the prediction runs at the edge where the item is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_chars.valid       <= 1'b0;
      name_chars.char_value  <= '0;
      name_chars.end_of_name <= 1'b0;
    end else begin
      if (name_chars.valid && name_chars.ready) begin
        predict_wire_bytes(in_flight);
      end
      if (!name_chars.valid || name_chars.ready) begin
        // a drain item waits until every expected byte has come out
        if (pending_chars.size() != 0 && !idle_now() &&
            !(pending_chars[0].drain_first && expected_bytes.size() != 0)) begin
          in_flight = pending_chars.pop_front();
          name_chars.valid       <= 1'b1;
          name_chars.char_value  <= in_flight.char_value;
          name_chars.end_of_name <= in_flight.end_of_name;
        end else begin
          name_chars.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and a field by field check of each byte
  always @(posedge clk_i or negedge rst_ni) begin
    wire_byte_t want;
    if (!rst_ni) begin
      wire_bytes.ready <= 1'b0;
    end else begin
      if (wire_bytes.valid && wire_bytes.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %h last %b root_after %b error %b", $time,
                   wire_bytes.byte_value, wire_bytes.last, wire_bytes.root_after,
                   wire_bytes.error);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (wire_bytes.byte_value !== want.byte_value) begin
            $display("%0t: byte_value expected %h actual %h", $time,
                     want.byte_value, wire_bytes.byte_value);
            fail_count++;
          end
          if (wire_bytes.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time,
                     want.last, wire_bytes.last);
            fail_count++;
          end
          if (wire_bytes.root_after !== want.root_after) begin
            $display("%0t: root_after expected %b actual %b", $time,
                     want.root_after, wire_bytes.root_after);
            fail_count++;
          end
          if (wire_bytes.error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time,
                     want.error, wire_bytes.error);
            fail_count++;
          end
        end
      end
      wire_bytes.ready <= !idle_now();
    end
  end

  // queues one item; a pending drain request lands on it
  task automatic queue_char(input logic [dnle_pkg::CHAR_W-1:0] ch, input logic eon);
    name_char_t it;
    it.char_value  = ch;
    it.end_of_name = eon;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    pending_chars.push_back(it);
    queued_count++;
  endtask

  // queues a label of random non-dot characters
  task automatic queue_label(input int unsigned len);
    logic [dnle_pkg::CHAR_W-1:0] ch;
    for (int unsigned i = 0; i < len; i++) begin
      do ch = dnle_pkg::CHAR_W'($urandom_range(0, 255)); while (ch == dnle_pkg::DOT_CHAR);
      queue_char(ch, 1'b0);
    end
  endtask

  initial begin
    int unsigned name_idx;
    int unsigned n_labels;
    int unsigned pick;
    int unsigned len;

    // directed: one-character label closed by a dot
    queue_char(8'h61, 1'b0);
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    // character extremes, then an end whose character is a dot and is ignored
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(dnle_pkg::DOT_CHAR, 1'b1);
    // end with nothing buffered
    queue_char(8'hFF, 1'b1);
    // leading dot, then a label, then two dots in a row
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    queue_char(8'h62, 1'b0);
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    // trailing dot before the end
    queue_char(8'h63, 1'b0);
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    queue_char(8'h41, 1'b1);
    // end flush of a real label, end character ignored
    queue_char(8'h64, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h80, 1'b1);

    // a full-length label and an overlong one, sent after a full drain
    drain_next = 1'b1;
    queue_label(dnle_pkg::MAX_LABEL);
    queue_char(dnle_pkg::DOT_CHAR, 1'b0);
    queue_label(dnle_pkg::MAX_LABEL + 3);
    queue_char(dnle_pkg::DOT_CHAR, 1'b1);

    // random names: mostly short labels, some empty, a few near or past the limit
    name_idx = 0;
    while (queued_count < NUM_ITEMS) begin
      name_idx++;
      if (name_idx % 40 == 0) drain_next = 1'b1;
      n_labels = $urandom_range(1, 4);
      for (int unsigned l = 0; l < n_labels; l++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) len = $urandom_range(dnle_pkg::MAX_LABEL - 3, dnle_pkg::MAX_LABEL + 3);
        else if (pick < 10) len = 0;
        else len = $urandom_range(1, 12);
        queue_label(len);
        if (l + 1 != n_labels) queue_char(dnle_pkg::DOT_CHAR, 1'b0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) queue_char(dnle_pkg::DOT_CHAR, 1'b0);
      // now and then a name runs into the next one with no end item
      if (pick < 95) queue_char(dnle_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
      // stray end items make empty names
      if ($urandom_range(0, 19) == 0) begin
        queue_char(dnle_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
      end
    end
    // close whatever label the last name left open
    queue_char(dnle_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || name_chars.valid) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d items pending, %0d bytes expected", $time,
             pending_chars.size(), expected_bytes.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### dns_name_label_encoder.f
rtl/dnle_pkg.sv
rtl/dnle_chan_if.sv
rtl/dnle_label_ram.sv
rtl/dns_name_label_encoder.sv
tb/tb_dns_name_label_encoder.sv
